/* rtl/cawrr_pkg.sv */
// Package for the congestion-aware weighted round-robin selector.
// Field widths, opcodes, reset constants and the pick decision type.
// No dependencies.
`default_nettype none

package cawrr_pkg;

   localparam int SLOTS     = 8;
   localparam int IDX_W     = 3;
   localparam int WEIGHT_W  = 8;
   localparam int MASK_W    = 8;
   localparam int CSR_IDX_W = 4;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd1;

   localparam logic OP_CLASSIFY = 1'b0;
   localparam logic OP_SET      = 1'b1;

   typedef struct packed {
      logic [IDX_W-1:0] sel;
      logic             none_eligible;
      logic             take;
      logic             reload;
   } decision_type;

endpackage

`default_nettype wire

/* rtl/cawrr_if.sv */
// Channel interfaces of the selector: request, response and register write.
// Depends on cawrr_pkg.
`default_nettype none

interface cawrr_req_if import cawrr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [MASK_W-1:0] ready_mask;
   logic [IDX_W-1:0]  channel;
   logic              congested_value;

   modport source (output valid, output op, output ready_mask, output channel,
                   output congested_value, input ready);
   modport sink   (input valid, input op, input ready_mask, input channel,
                   input congested_value, output ready);
endinterface

interface cawrr_rsp_if import cawrr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] selected_output;
   logic             none_eligible;

   modport source (output valid, output selected_output, output none_eligible,
                   input ready);
   modport sink   (input valid, input selected_output, input none_eligible,
                   output ready);
endinterface

interface cawrr_csr_if import cawrr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WEIGHT_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/cawrr_pick.sv */
// Output pick: lowest ready, uncongested output with credit, else reload pick.
// Depends on cawrr_pkg.
`default_nettype none

module cawrr_pick import cawrr_pkg::*; #(
   parameter int NUM_OUTPUTS = 4
) (
   input  wire logic [NUM_OUTPUTS-1:0] ready_mask,
   input  wire logic [NUM_OUTPUTS-1:0] congested,
   input  wire logic [WEIGHT_W-1:0]    credit [NUM_OUTPUTS],
   input  wire logic [WEIGHT_W-1:0]    weight [NUM_OUTPUTS],
   output decision_type                decision
);

   localparam logic [IDX_W-1:0] DROP = IDX_W'(NUM_OUTPUTS - 1);

   logic [NUM_OUTPUTS-1:0] avail;
   logic [NUM_OUTPUTS-1:0] cand_credit;
   logic [NUM_OUTPUTS-1:0] cand_reload;
   logic [IDX_W-1:0]       sel_credit;
   logic [IDX_W-1:0]       sel_reload;

   always_comb begin
      avail = ready_mask & ~congested;
      sel_credit = DROP;
      sel_reload = DROP;
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
         cand_credit[i] = avail[i] && (credit[i] != '0);
         cand_reload[i] = avail[i] && (weight[i] != '0);
      end
      for (int i = NUM_OUTPUTS - 1; i >= 0; i--) begin
         if (cand_credit[i]) begin
            sel_credit = IDX_W'(i);
         end
         if (cand_reload[i]) begin
            sel_reload = IDX_W'(i);
         end
      end
   end

   always_comb begin
      decision = '{sel: DROP, none_eligible: 1'b0, take: 1'b0, reload: 1'b0};
      if (|cand_credit) begin
         decision.sel  = sel_credit;
         decision.take = 1'b1;
      end else if (!(|avail)) begin
         decision.none_eligible = 1'b1;
      end else begin
         decision.reload = 1'b1;
         if (|cand_reload) begin
            decision.sel  = sel_reload;
            decision.take = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/congestion_aware_wrr_selector.sv */
// Top level of the congestion-aware weighted round-robin selector.
// Depends on cawrr_pkg, cawrr_if.sv and cawrr_pick.
//
// A request is taken into an input register and decided from there once it can advance:
// the pick and the credit/congestion update happen together in the same cycle, so one
// request is accepted every clock while responses are taken, and a classify
// request's response passes from the input register through the pick into the
// response register. A held response stalls the next classify request. Set requests
// update the congestion flag and produce no response. Weight writes also load the
// bucket of that output; they are taken in any cycle, one per clock.
`default_nettype none

module congestion_aware_wrr_selector import cawrr_pkg::*; #(
   parameter int NUM_OUTPUTS = 4
) (
   input  wire logic   clock,
   input  wire logic   reset,
   cawrr_req_if.sink   req_bus,
   cawrr_rsp_if.source rsp_bus,
   cawrr_csr_if.sink   csr_bus
);

   localparam int SEL_W = $clog2(NUM_OUTPUTS);
   localparam logic [IDX_W-1:0] DROP = IDX_W'(NUM_OUTPUTS - 1);

   logic                   in_valid_ff;
   logic                   in_op_ff;
   logic [MASK_W-1:0]      in_mask_ff;
   logic [IDX_W-1:0]       in_chan_ff;
   logic                   in_cval_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]       out_sel_ff;
   logic                   out_none_ff;

   logic [WEIGHT_W-1:0]    weight_ff [NUM_OUTPUTS];
   logic [WEIGHT_W-1:0]    weight_in [NUM_OUTPUTS];
   logic [WEIGHT_W-1:0]    credit_ff [NUM_OUTPUTS];
   logic [WEIGHT_W-1:0]    credit_in [NUM_OUTPUTS];
   logic [NUM_OUTPUTS-1:0] cong_ff, cong_in;

   logic                   advance;
   logic                   classify_go;
   logic                   set_go;
   logic                   req_take;
   logic                   csr_wr;
   decision_type           dec;

   assign advance = in_valid_ff &&
                    (in_op_ff == OP_SET || !out_valid_ff || rsp_bus.ready);
   assign classify_go = advance && (in_op_ff == OP_CLASSIFY);
   assign set_go = advance && (in_op_ff == OP_SET) &&
                   ({1'b0, in_chan_ff} < (IDX_W + 1)'(NUM_OUTPUTS));
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;

   assign csr_bus.ready = 1'b1;
   assign csr_wr = csr_bus.valid && (csr_bus.index < CSR_IDX_W'(NUM_OUTPUTS));

   cawrr_pick #(
      .NUM_OUTPUTS (NUM_OUTPUTS)
   ) u_pick (
      .ready_mask (in_mask_ff[NUM_OUTPUTS-1:0]),
      .congested  (cong_ff),
      .credit     (credit_ff),
      .weight     (weight_ff),
      .decision   (dec)
   );

   always_comb begin
      out_valid_in = classify_go ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
      cong_in = cong_ff;
      if (set_go) begin
         cong_in[in_chan_ff[SEL_W-1:0]] = in_cval_ff;
      end
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
         weight_in[i] = weight_ff[i];
         credit_in[i] = credit_ff[i];
         if (classify_go && dec.reload && !cong_ff[i]) begin
            credit_in[i] = weight_ff[i];
         end
         if (classify_go && dec.take && dec.sel == IDX_W'(i)) begin
            credit_in[i] = credit_in[i] - 1'b1;
         end
         if (csr_wr && csr_bus.index[SEL_W-1:0] == SEL_W'(i)) begin
            weight_in[i] = csr_bus.data;
            credit_in[i] = csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cong_ff      <= '0;
         for (int i = 0; i < NUM_OUTPUTS; i++) begin
            weight_ff[i] <= WEIGHT_RESET;
            credit_ff[i] <= WEIGHT_RESET;
         end
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         out_valid_ff <= out_valid_in;
         cong_ff      <= cong_in;
         weight_ff    <= weight_in;
         credit_ff    <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_bus.op;
         in_mask_ff <= req_bus.ready_mask;
         in_chan_ff <= req_bus.channel;
         in_cval_ff <= req_bus.congested_value;
      end
      if (classify_go) begin
         out_sel_ff  <= dec.sel;
         out_none_ff <= dec.none_eligible;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.selected_output = out_sel_ff;
   assign rsp_bus.none_eligible   = out_none_ff;

   a_none_is_drop: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_none_ff |-> out_sel_ff == DROP)
      else $error("none_eligible response without drop bin");

   a_sel_in_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ({1'b0, out_sel_ff} < (IDX_W + 1)'(NUM_OUTPUTS)))
      else $error("selected output beyond outputs");

   a_take_is_ready: assert property (@(posedge clock) disable iff (reset)
      classify_go && dec.take |-> in_mask_ff[dec.sel[SEL_W-1:0]] &&
                                  !cong_ff[dec.sel[SEL_W-1:0]])
      else $error("credit taken from an output that is not ready or congested");

   a_held_request: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_op_ff))
      else $error("stalled request lost");

endmodule

`default_nettype wire
